// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL, used by the command queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CLS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define CLS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CLS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CLS_ASSERT(label, clk, rst, prop, msg)
`define CLS_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define CLS_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/cls_pkg.sv =====
// Types, codes and constants of the character-LCD bus sequencer.
package cls_pkg;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] value;
  } req_t;

  typedef struct packed {
    logic        reg_select;
    logic        read_write;
    logic        enable;
    logic [7:0]  data_bits;
    logic [10:0] delay_after_ms;
    logic        last;
  } step_t;

  // one command for the back end: a byte transfer or the power-on wait
  typedef struct packed {
    logic        is_wait;
    logic        rs;
    logic [7:0]  data;
    logic [10:0] delay_end;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic       bus_full_width;
    logic       tall_font;
    logic [1:0] row_count;
    logic [5:0] row_length;
  } cfg_t;

  typedef enum logic {
    F_IDLE,
    F_INIT
  } front_state_t;

  localparam logic [1:0] ACT_INIT  = 2'd0;
  localparam logic [1:0] ACT_INSTR = 2'd1;
  localparam logic [1:0] ACT_DATA  = 2'd2;
  localparam logic [1:0] ACT_POS   = 2'd3;

  localparam logic [1:0] REG_BUS_WIDTH  = 2'd0;
  localparam logic [1:0] REG_TALL_FONT  = 2'd1;
  localparam logic [1:0] REG_ROW_COUNT  = 2'd2;
  localparam logic [1:0] REG_ROW_LENGTH = 2'd3;

  localparam logic [7:0] CMD_FUNC_SET  = 8'h20;
  localparam logic [7:0] FS_BUS8       = 8'h10;
  localparam logic [7:0] FS_LINES2     = 8'h08;
  localparam logic [7:0] FS_FONT10     = 8'h04;
  localparam logic [7:0] CMD_DISP_CTRL = 8'h0F;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_HOME      = 8'h02;
  localparam logic [7:0] CMD_DDRAM     = 8'h80;
  localparam logic [7:0] DDRAM_LINE2   = 8'h40;

  localparam logic [10:0] DLY_STEP  = 11'd1;
  localparam logic [10:0] DLY_POWER = 11'd40;
  localparam logic [10:0] DLY_SHORT = 11'd46;
  localparam logic [10:0] DLY_LONG  = 11'd1601;

  localparam logic [2:0] INIT_LAST = 3'd6;

  function automatic cmd_t init_cmd(input logic [2:0] idx, input logic [7:0] fs);
    cmd_t c;
    c = '{is_wait: 1'b0, rs: 1'b0, data: fs, delay_end: DLY_SHORT, last: 1'b0};
    case (idx)
      3'd0: begin
        c.is_wait   = 1'b1;
        c.data      = 8'h00;
        c.delay_end = DLY_POWER;
      end
      3'd1, 3'd2: c.data = fs;
      3'd3: c.data = CMD_DISP_CTRL;
      3'd4: begin
        c.data      = CMD_CLEAR;
        c.delay_end = DLY_LONG;
      end
      3'd5: c.data = CMD_ENTRY;
      3'd6: begin
        c.data      = CMD_HOME;
        c.delay_end = DLY_LONG;
        c.last      = 1'b1;
      end
      default: c.data = fs;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/cls_cfg.sv =====
// APB register bank holding the bus and display configuration.
module cls_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cls_pkg::cfg_t     cfg
);

  logic we;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign we     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bus_full_width <= 1'b0;
      cfg.tall_font      <= 1'b0;
      cfg.row_count      <= 2'd2;
      cfg.row_length     <= 6'd16;
    end else if (we) begin
      case (idx)
        cls_pkg::REG_BUS_WIDTH:  cfg.bus_full_width <= pwdata[0];
        cls_pkg::REG_TALL_FONT:  cfg.tall_font      <= pwdata[0];
        cls_pkg::REG_ROW_COUNT:  cfg.row_count      <= pwdata[1:0];
        cls_pkg::REG_ROW_LENGTH: cfg.row_length     <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      cls_pkg::REG_BUS_WIDTH:  prdata[0]   = cfg.bus_full_width;
      cls_pkg::REG_TALL_FONT:  prdata[0]   = cfg.tall_font;
      cls_pkg::REG_ROW_COUNT:  prdata[1:0] = cfg.row_count;
      cls_pkg::REG_ROW_LENGTH: prdata[5:0] = cfg.row_length;
      default: prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/cls_front.sv =====
// Request front end: decodes requests into byte commands for the queue.
module cls_front (
  input  logic              clk,
  input  logic              rst,
  input  cls_pkg::cfg_t     cfg,
  input  logic              req_valid,
  output logic              req_ready,
  input  cls_pkg::req_t     req,
  input  logic              q_full,
  output logic              push,
  output cls_pkg::cmd_t     push_cmd
);

  cls_pkg::front_state_t state, state_next;
  logic [2:0] idx, idx_next;
  logic [7:0] fs;
  logic [7:0] limit;
  logic [7:0] pos;
  logic       pos_ok;
  logic       accept;

  assign fs = cls_pkg::CMD_FUNC_SET
            | (cfg.bus_full_width ? cls_pkg::FS_BUS8 : 8'h00)
            | (cfg.tall_font ? cls_pkg::FS_FONT10 : 8'h00)
            | (cfg.row_count == 2'd2 ? cls_pkg::FS_LINES2 : 8'h00);

  assign limit  = 8'({6'd0, cfg.row_count} * cfg.row_length);
  assign pos_ok = req.value < limit;
  assign pos    = (req.value >= {2'b00, cfg.row_length})
                ? ((req.value - {2'b00, cfg.row_length}) | cls_pkg::DDRAM_LINE2 |
                   cls_pkg::CMD_DDRAM)
                : (req.value | cls_pkg::CMD_DDRAM);

  assign accept = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cls_pkg::F_IDLE;
      idx   <= 3'd0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    case (state)
      cls_pkg::F_IDLE: begin
        if (accept && req.action == cls_pkg::ACT_INIT) begin
          state_next = cls_pkg::F_INIT;
          idx_next   = 3'd0;
        end
      end
      cls_pkg::F_INIT: begin
        if (!q_full) begin
          idx_next = idx + 3'd1;
          if (idx == cls_pkg::INIT_LAST) state_next = cls_pkg::F_IDLE;
        end
      end
      default: state_next = cls_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    push      = 1'b0;
    push_cmd  = '{is_wait: 1'b0, rs: 1'b0, data: req.value,
                  delay_end: cls_pkg::DLY_STEP, last: 1'b1};
    case (state)
      cls_pkg::F_IDLE: begin
        req_ready = !q_full;
        case (req.action)
          cls_pkg::ACT_INIT: push = 1'b0;
          cls_pkg::ACT_INSTR: push = accept;
          cls_pkg::ACT_DATA: begin
            push              = accept;
            push_cmd.rs       = 1'b1;
            push_cmd.delay_end = cls_pkg::DLY_SHORT;
          end
          cls_pkg::ACT_POS: begin
            push               = accept && pos_ok;
            push_cmd.data      = pos;
            push_cmd.delay_end = cls_pkg::DLY_SHORT;
          end
          default: push = 1'b0;
        endcase
      end
      cls_pkg::F_INIT: begin
        push     = !q_full;
        push_cmd = cls_pkg::init_cmd(idx, fs);
      end
      default: push = 1'b0;
    endcase
  end

endmodule

// ===== hw/rtl/cls_queue.sv =====
// Short command queue between the front end and the step emitter.
`include "assert_macros.svh"
module cls_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cls_pkg::cmd_t     push_cmd,
  input  logic              pop,
  output cls_pkg::cmd_t     head,
  output logic              empty,
  output logic              full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

  cls_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_MAX);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_MAX) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_MAX) ? '0 : rd_ptr + PW'(1);
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  `CLS_ASSERT_IMP(a_no_overflow, clk, rst, push, !full, "push into full queue")
  `CLS_ASSERT_IMP(a_no_underflow, clk, rst, pop, !empty, "pop from empty queue")
  `CLS_ASSERT(a_count_bound, clk, rst, count <= CNT_MAX, "queue count out of range")
  `CLS_ASSERT_NXT(a_push_grows, clk, rst, push && !pop, count == $past(count) + CW'(1), "count did not grow")

endmodule

// ===== hw/rtl/cls_back.sv =====
// Step emitter: expands queued commands into EN-high / EN-low pin steps.
module cls_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              bus_full_width,
  input  logic              q_empty,
  input  cls_pkg::cmd_t     head,
  output logic              pop,
  output logic              step_valid,
  input  logic              step_ready,
  output cls_pkg::step_t    step
);

  logic [1:0] sub, sub_next;
  logic       final_step;
  logic       load;
  logic [3:0] nib;
  cls_pkg::step_t step_next;

  assign load = !q_empty && (!step_valid || step_ready);
  assign final_step = head.is_wait ? 1'b1
                    : (bus_full_width ? (sub == 2'd1) : (sub == 2'd3));
  assign pop = load && final_step;
  assign sub_next = final_step ? 2'd0 : sub + 2'd1;
  assign nib = sub[1] ? head.data[3:0] : head.data[7:4];

  always_comb begin
    step_next.reg_select     = head.rs;
    step_next.read_write     = 1'b0;
    step_next.enable         = !sub[0];
    step_next.data_bits      = bus_full_width ? head.data : {4'h0, nib};
    step_next.delay_after_ms = final_step ? head.delay_end : cls_pkg::DLY_STEP;
    step_next.last           = final_step && head.last;
    if (head.is_wait) begin
      step_next.enable    = 1'b0;
      step_next.data_bits = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub        <= 2'd0;
      step_valid <= 1'b0;
    end else begin
      if (load) begin
        sub        <= sub_next;
        step_valid <= 1'b1;
      end else if (step_ready) begin
        step_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) step <= step_next;
  end

endmodule

// ===== hw/rtl/char_lcd_bus_sequencer_top.sv =====
// Top level of the character-LCD bus sequencer.
// Each request beat becomes a run of pin-step beats, one per clock while the step
// output is taken: init gives 25 steps on a four-bit bus and 13 on an eight-bit bus,
// a write instruction, write data or in-range set position gives 4 or 2, and an
// out-of-range position gives none. Requests are taken while the command queue has
// room, and an init holds the request side while it queues its 7 commands; it
// pushes no command while the queue is full.
// The ms delays are only reported on each step; pacing is left to the pin driver.
module char_lcd_bus_sequencer_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              req_valid,
  output logic              req_ready,
  input  cls_pkg::req_t     req,
  output logic              step_valid,
  input  logic              step_ready,
  output cls_pkg::step_t    step
);

  cls_pkg::cfg_t cfg;
  cls_pkg::cmd_t push_cmd;
  cls_pkg::cmd_t head;
  logic push, pop, q_empty, q_full;

  cls_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cls_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  cls_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  cls_back u_back (
    .clk            (clk),
    .rst            (rst),
    .bus_full_width (cfg.bus_full_width),
    .q_empty        (q_empty),
    .head           (head),
    .pop            (pop),
    .step_valid     (step_valid),
    .step_ready     (step_ready),
    .step           (step)
  );

endmodule

// ===== dv/char_lcd_bus_sequencer_top_test.sv =====
// Self-checking testbench for the character-LCD bus sequencer: random requests, predicted pin steps.
`timescale 1ns / 1ps

module char_lcd_bus_sequencer_top_test;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [3:0]     paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;
  logic           req_valid = 1'b0;
  logic           req_ready;
  cls_pkg::req_t  req_beat = '0;
  logic           step_valid;
  logic           step_ready = 1'b0;
  cls_pkg::step_t step_beat;

  cls_pkg::cfg_t  lcd_cfg;
  cls_pkg::req_t  pending_reqs[$];
  cls_pkg::step_t steps_due[$];
  int    errors = 0;
  int    req_beats = 0;
  int    holdoff_left = 0;
  bit    holdoff_done = 1'b0;
  wire   no_gaps = (req_beats >= 110) && (req_beats < 150);

  char_lcd_bus_sequencer_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req_beat),
    .step_valid (step_valid),
    .step_ready (step_ready),
    .step       (step_beat)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---- step predictor ----
  function automatic void push_step(input logic rs, input logic en, input logic [7:0] d,
                                    input logic [10:0] dly);
    cls_pkg::step_t s;
    s = '{reg_select: rs, read_write: 1'b0, enable: en, data_bits: d,
          delay_after_ms: dly, last: 1'b0};
    steps_due.push_back(s);
  endfunction

  function automatic void send_byte(input logic rs, input logic [7:0] b,
                                    input logic [10:0] end_dly);
    if (lcd_cfg.bus_full_width) begin
      push_step(rs, 1'b1, b, cls_pkg::DLY_STEP);
      push_step(rs, 1'b0, b, end_dly);
    end else begin
      push_step(rs, 1'b1, {4'h0, b[7:4]}, cls_pkg::DLY_STEP);
      push_step(rs, 1'b0, {4'h0, b[7:4]}, cls_pkg::DLY_STEP);
      push_step(rs, 1'b1, {4'h0, b[3:0]}, cls_pkg::DLY_STEP);
      push_step(rs, 1'b0, {4'h0, b[3:0]}, end_dly);
    end
  endfunction

  function automatic void predict_steps(input cls_pkg::req_t r);
    int             n_start;
    int unsigned    span;
    int unsigned    pos;
    logic [7:0]     fs;
    cls_pkg::step_t tail;
    n_start = steps_due.size();
    case (r.action)
      cls_pkg::ACT_INIT: begin
        fs = cls_pkg::CMD_FUNC_SET;
        if (lcd_cfg.bus_full_width) fs = fs | cls_pkg::FS_BUS8;
        if (lcd_cfg.tall_font) fs = fs | cls_pkg::FS_FONT10;
        if (lcd_cfg.row_count == 2'd2) fs = fs | cls_pkg::FS_LINES2;
        push_step(1'b0, 1'b0, 8'h00, cls_pkg::DLY_POWER);
        send_byte(1'b0, fs, cls_pkg::DLY_SHORT);
        send_byte(1'b0, fs, cls_pkg::DLY_SHORT);
        send_byte(1'b0, cls_pkg::CMD_DISP_CTRL, cls_pkg::DLY_SHORT);
        send_byte(1'b0, cls_pkg::CMD_CLEAR, cls_pkg::DLY_LONG);
        send_byte(1'b0, cls_pkg::CMD_ENTRY, cls_pkg::DLY_SHORT);
        send_byte(1'b0, cls_pkg::CMD_HOME, cls_pkg::DLY_LONG);
      end
      cls_pkg::ACT_INSTR: send_byte(1'b0, r.value, cls_pkg::DLY_STEP);
      cls_pkg::ACT_DATA:  send_byte(1'b1, r.value, cls_pkg::DLY_SHORT);
      default: begin
        span = 32'(lcd_cfg.row_count) * 32'(lcd_cfg.row_length);
        if (32'(r.value) < span) begin
          pos = 32'(r.value);
          if (pos >= 32'(lcd_cfg.row_length))
            pos = (pos - 32'(lcd_cfg.row_length)) | 32'(cls_pkg::DDRAM_LINE2);
          pos = pos | 32'(cls_pkg::CMD_DDRAM);
          send_byte(1'b0, pos[7:0], cls_pkg::DLY_SHORT);
        end
      end
    endcase
    if (steps_due.size() > n_start) begin
      tail = steps_due.pop_back();
      tail.last = 1'b1;
      steps_due.push_back(tail);
    end
  endfunction

  task automatic report(input string field, input int unsigned exp_v, input int unsigned act_v);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
    errors++;
  endtask

  // ---- request driver ----
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_ready) begin
      if (req_valid) void'(pending_reqs.pop_front());
      if (pending_reqs.size() != 0 && (no_gaps || $urandom_range(99) >= 29)) begin
        req_valid <= 1'b1;
        req_beat  <= pending_reqs[0];
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // ---- step receiver, with one long hold-off ----
  always @(posedge clk) begin
    if (rst) begin
      step_ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
      step_ready   <= 1'b0;
    end else if (!holdoff_done && req_beats >= 30) begin
      holdoff_done <= 1'b1;
      holdoff_left <= 300;
      step_ready   <= 1'b0;
    end else begin
      step_ready <= no_gaps || ($urandom_range(99) >= 29);
    end
  end

  // ---- monitor: predicts on request beats, checks step beats ----
  always @(posedge clk) begin
    cls_pkg::step_t exp_s;
    if (!rst) begin
      if (req_valid && req_ready) begin
        predict_steps(req_beat);
        req_beats <= req_beats + 1;
      end
      if (step_valid && step_ready) begin
        if (steps_due.size() == 0) begin
          $display("%0t: unexpected step, expected none, got %h", $time, step_beat);
          errors++;
        end else begin
          exp_s = steps_due.pop_front();
          if (exp_s.reg_select !== step_beat.reg_select)
            report("reg_select", 32'(exp_s.reg_select), 32'(step_beat.reg_select));
          if (exp_s.read_write !== step_beat.read_write)
            report("read_write", 32'(exp_s.read_write), 32'(step_beat.read_write));
          if (exp_s.enable !== step_beat.enable)
            report("enable", 32'(exp_s.enable), 32'(step_beat.enable));
          if (exp_s.data_bits !== step_beat.data_bits)
            report("data_bits", 32'(exp_s.data_bits), 32'(step_beat.data_bits));
          if (exp_s.delay_after_ms !== step_beat.delay_after_ms)
            report("delay_after_ms", 32'(exp_s.delay_after_ms),
                   32'(step_beat.delay_after_ms));
          if (exp_s.last !== step_beat.last)
            report("last", 32'(exp_s.last), 32'(step_beat.last));
        end
      end
    end
  end

  // ---- stimulus ----
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      cls_pkg::REG_BUS_WIDTH: lcd_cfg.bus_full_width = val[0];
      cls_pkg::REG_TALL_FONT: lcd_cfg.tall_font      = val[0];
      cls_pkg::REG_ROW_COUNT: lcd_cfg.row_count      = val[1:0];
      default:                lcd_cfg.row_length     = val[5:0];
    endcase
  endtask

  task automatic set_cfg(input logic bw, input logic tf, input logic [1:0] rc,
                         input logic [5:0] rl);
    write_reg(cls_pkg::REG_BUS_WIDTH, {31'd0, bw});
    write_reg(cls_pkg::REG_TALL_FONT, {31'd0, tf});
    write_reg(cls_pkg::REG_ROW_COUNT, {30'd0, rc});
    write_reg(cls_pkg::REG_ROW_LENGTH, {26'd0, rl});
  endtask

  task automatic queue_req(input logic [1:0] act, input logic [7:0] val);
    cls_pkg::req_t r;
    r.action = act;
    r.value  = val;
    pending_reqs.push_back(r);
  endtask

  // an out-of-range position gives no step, so allow the block time to settle
  task automatic drain();
    while (pending_reqs.size() != 0 || req_valid || steps_due.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic queue_random_req();
    int unsigned pick;
    int unsigned span;
    int unsigned hi;
    pick = $urandom_range(99);
    span = 32'(lcd_cfg.row_count) * 32'(lcd_cfg.row_length);
    hi   = (span + 2 > 255) ? 255 : span + 2;
    if (pick < 8)       queue_req(cls_pkg::ACT_INIT, 8'($urandom_range(255)));
    else if (pick < 35) queue_req(cls_pkg::ACT_INSTR, 8'($urandom_range(255)));
    else if (pick < 65) queue_req(cls_pkg::ACT_DATA, 8'($urandom_range(255)));
    else if ($urandom_range(99) < 75) queue_req(cls_pkg::ACT_POS, 8'($urandom_range(hi)));
    else queue_req(cls_pkg::ACT_POS, 8'($urandom_range(255)));
  endtask

  initial begin
    logic       bw_tab[5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    logic       tf_tab[5] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
    logic [1:0] rc_tab[5] = '{2'd1, 2'd2, 2'd2, 2'd3, 2'd0};
    logic [5:0] rl_tab[5] = '{6'd40, 6'd1, 6'd40, 6'd63, 6'd0};
    lcd_cfg = '{bus_full_width: 1'b0, tall_font: 1'b0, row_count: 2'd2, row_length: 6'd16};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, reset settings: two lines of sixteen
    queue_req(cls_pkg::ACT_INIT, 8'h00);
    queue_req(cls_pkg::ACT_INSTR, 8'h00);
    queue_req(cls_pkg::ACT_INSTR, 8'hFF);
    queue_req(cls_pkg::ACT_DATA, 8'h00);
    queue_req(cls_pkg::ACT_DATA, 8'hFF);
    queue_req(cls_pkg::ACT_POS, 8'd0);
    queue_req(cls_pkg::ACT_POS, 8'd15);
    queue_req(cls_pkg::ACT_POS, 8'd16);
    queue_req(cls_pkg::ACT_POS, 8'd31);
    queue_req(cls_pkg::ACT_POS, 8'd32);
    queue_req(cls_pkg::ACT_POS, 8'd255);
    queue_req(cls_pkg::ACT_INSTR, 8'hA5);
    queue_req(cls_pkg::ACT_DATA, 8'h5A);
    queue_req(cls_pkg::ACT_INIT, 8'hFF);
    queue_req(cls_pkg::ACT_POS, 8'd17);
    queue_req(cls_pkg::ACT_DATA, 8'h3C);
    for (int i = 0; i < 26; i++) queue_random_req();
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 5)
        set_cfg(bw_tab[ph], tf_tab[ph], rc_tab[ph], rl_tab[ph]);
      else
        set_cfg(1'($urandom_range(1)), 1'($urandom_range(1)), 2'($urandom_range(3)),
                6'($urandom_range(63)));
      @(negedge clk);
      for (int i = 0; i < 23; i++) queue_random_req();
      drain();
    end

    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/cls_pkg.sv
hw/rtl/cls_cfg.sv
hw/rtl/cls_front.sv
hw/rtl/cls_queue.sv
hw/rtl/cls_back.sv
hw/rtl/char_lcd_bus_sequencer_top.sv
dv/char_lcd_bus_sequencer_top_test.sv
